>>> src/rgbhsl_pkg.sv
// ----------------------------------------------------------------------------
// rgbhsl_pkg
// Request and result types, divider lane types and constants shared by the
// RGB to HSL converter pipeline.
// ----------------------------------------------------------------------------
package rgbhsl_pkg;

  localparam int unsigned DIV_STEPS    = 16;
  localparam int unsigned PIPE_LATENCY = DIV_STEPS + 3;
  localparam logic [14:0] HUE_FULL_Q   = 15'd23040;
  localparam logic [15:0] SAT_MAX_Q    = 16'hFFFF;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } in_pix_t;

  typedef struct packed {
    logic [14:0] hue_q;
    logic [8:0]  lightness_sum;
    logic [15:0] saturation_q;
    logic        is_gray;
  } out_pix_t;

  typedef struct packed {
    logic [7:0]           rem;
    logic [DIV_STEPS-1:0] qx;
    logic [7:0]           dvs;
  } div_lane_t;

  typedef struct packed {
    div_lane_t  hue;
    div_lane_t  sat;
    logic [8:0] lightness_sum;
    logic       is_gray;
  } div_word_t;

endpackage

>>> src/rgbhsl_prep.sv
// ----------------------------------------------------------------------------
// rgbhsl_prep
// Two pipeline stages: max/min, sector offset and saturation divisor, then
// the constant scaling of both dividends for the divider chain.
// ----------------------------------------------------------------------------
module rgbhsl_prep
  import rgbhsl_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      valid_i,
  input  in_pix_t   pix_i,
  output logic      valid_o,
  output div_word_t word_o
);

  logic [7:0]        mx, mn, d;
  logic [8:0]        sum;
  logic [7:0]        den;
  logic signed [11:0] t_s;
  logic [10:0]       t_nxt;

  logic              valid_a_r;
  logic [10:0]       t_r;
  logic [7:0]        d_r;
  logic [7:0]        den_r;
  logic [8:0]        sum_r;
  logic              gray_r;

  logic [23:0]       hue_x;
  logic [23:0]       sat_x;
  logic              valid_b_r;
  div_word_t         word_r;
  div_word_t         word_nxt;

  always_comb begin
    logic signed [11:0] rs, gs, bs, ds;
    rs = {4'd0, pix_i.red};
    gs = {4'd0, pix_i.green};
    bs = {4'd0, pix_i.blue};
    if (pix_i.red >= pix_i.green && pix_i.red >= pix_i.blue) begin
      mx = pix_i.red;
    end else if (pix_i.green >= pix_i.blue) begin
      mx = pix_i.green;
    end else begin
      mx = pix_i.blue;
    end
    if (pix_i.red <= pix_i.green && pix_i.red <= pix_i.blue) begin
      mn = pix_i.red;
    end else if (pix_i.green <= pix_i.blue) begin
      mn = pix_i.green;
    end else begin
      mn = pix_i.blue;
    end
    d   = mx - mn;
    sum = {1'b0, mx} + {1'b0, mn};
    den = (sum <= 9'd255) ? sum[7:0] : 8'(9'd510 - sum);
    ds  = {4'd0, d};
    if (pix_i.red >= pix_i.green && pix_i.red >= pix_i.blue) begin
      t_s = gs - bs;
      if (t_s < 0) begin
        t_s = t_s + (ds <<< 2) + (ds <<< 1);
      end
    end else if (pix_i.green >= pix_i.blue) begin
      t_s = bs - rs + (ds <<< 1);
    end else begin
      t_s = rs - gs + (ds <<< 2);
    end
    t_nxt = t_s[10:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_a_r <= 1'b0;
    end else begin
      valid_a_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    t_r    <= t_nxt;
    d_r    <= d;
    den_r  <= den;
    sum_r  <= sum;
    gray_r <= (d == 8'd0);
  end

  always_comb begin
    hue_x = ({13'd0, t_r} << 12) - ({13'd0, t_r} << 8);
    sat_x = ({16'd0, d_r} << 16) - {16'd0, d_r};
    word_nxt.hue.rem      = hue_x[23:16];
    word_nxt.hue.qx       = hue_x[15:0];
    word_nxt.hue.dvs      = gray_r ? 8'd1 : d_r;
    word_nxt.sat.rem      = sat_x[23:16];
    word_nxt.sat.qx       = sat_x[15:0];
    word_nxt.sat.dvs      = gray_r ? 8'd1 : den_r;
    word_nxt.lightness_sum = sum_r;
    word_nxt.is_gray      = gray_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_b_r <= 1'b0;
    end else begin
      valid_b_r <= valid_a_r;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign valid_o = valid_b_r;
  assign word_o  = word_r;

endmodule

>>> src/rgbhsl_div_stage.sv
// ----------------------------------------------------------------------------
// rgbhsl_div_stage
// One restoring division step for the hue and the saturation lanes.
// ----------------------------------------------------------------------------
module rgbhsl_div_stage
  import rgbhsl_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      valid_i,
  input  div_word_t word_i,
  output logic      valid_o,
  output div_word_t word_o
);

  logic      valid_r;
  div_word_t word_r;
  div_word_t word_nxt;

  function automatic div_lane_t lane_step(input div_lane_t l);
    div_lane_t  o;
    logic [8:0] p;
    p     = {l.rem, l.qx[DIV_STEPS-1]};
    o.dvs = l.dvs;
    if (p >= {1'b0, l.dvs}) begin
      o.rem = 8'(p - {1'b0, l.dvs});
      o.qx  = {l.qx[DIV_STEPS-2:0], 1'b1};
    end else begin
      o.rem = p[7:0];
      o.qx  = {l.qx[DIV_STEPS-2:0], 1'b0};
    end
    return o;
  endfunction

  always_comb begin
    word_nxt     = word_i;
    word_nxt.hue = lane_step(word_i.hue);
    word_nxt.sat = lane_step(word_i.sat);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign valid_o = valid_r;
  assign word_o  = word_r;

endmodule

>>> src/rgbhsl_round.sv
// ----------------------------------------------------------------------------
// rgbhsl_round
// Output stage: round both quotients to nearest, wrap hue, clamp saturation,
// zero gray pixels.
// ----------------------------------------------------------------------------
module rgbhsl_round
  import rgbhsl_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      valid_i,
  input  div_word_t word_i,
  output logic      valid_o,
  output out_pix_t  pix_o
);

  logic       valid_r;
  out_pix_t   pix_r;
  out_pix_t   pix_nxt;
  logic       hue_up, sat_up;
  logic [16:0] hue_sum, sat_sum;

  always_comb begin
    hue_up  = {word_i.hue.rem, 1'b0} >= {1'b0, word_i.hue.dvs};
    sat_up  = {word_i.sat.rem, 1'b0} >= {1'b0, word_i.sat.dvs};
    hue_sum = {1'b0, word_i.hue.qx} + {16'd0, hue_up};
    sat_sum = {1'b0, word_i.sat.qx} + {16'd0, sat_up};
    pix_nxt.lightness_sum = word_i.lightness_sum;
    pix_nxt.is_gray       = word_i.is_gray;
    if (word_i.is_gray || hue_sum[14:0] == HUE_FULL_Q) begin
      pix_nxt.hue_q = 15'd0;
    end else begin
      pix_nxt.hue_q = hue_sum[14:0];
    end
    if (word_i.is_gray) begin
      pix_nxt.saturation_q = 16'd0;
    end else if (sat_sum[16]) begin
      pix_nxt.saturation_q = SAT_MAX_Q;
    end else begin
      pix_nxt.saturation_q = sat_sum[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    pix_r <= pix_nxt;
  end

  assign valid_o = valid_r;
  assign pix_o   = pix_r;

endmodule

>>> src/rgb_to_hsl_converter.sv
// ----------------------------------------------------------------------------
// rgb_to_hsl_converter
// Pipelined RGB to HSL conversion with fixed point hue and saturation.
// ----------------------------------------------------------------------------
//   channel   ports                      handshake
//   request   in_data (red,green,blue)   start, busy
//   result    out_data (hue_q,...)       out_valid, one-cycle strobe
//
//   One request per cycle; busy stays low.
//   The pipeline has two prep stages, 16 divider steps (one quotient
//   bit each, shared by the hue and saturation divisions), one round stage.
//   Synchronous reset clears the valid bits; requests in flight are dropped.
//   The receiver cannot stall, so the pipeline never holds.
// ----------------------------------------------------------------------------
module rgb_to_hsl_converter
  import rgbhsl_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  in_pix_t  in_data,
  output logic     out_valid,
  output out_pix_t out_data
);

  logic      div_valid [0:DIV_STEPS];
  div_word_t div_word  [0:DIV_STEPS];

  assign busy = 1'b0;

  rgbhsl_prep u_prep (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (start),
    .pix_i   (in_data),
    .valid_o (div_valid[0]),
    .word_o  (div_word[0])
  );

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    rgbhsl_div_stage u_stage (
      .clk     (clk),
      .rst_n   (rst_n),
      .valid_i (div_valid[i]),
      .word_i  (div_word[i]),
      .valid_o (div_valid[i+1]),
      .word_o  (div_word[i+1])
    );
  end

  rgbhsl_round u_round (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (div_valid[DIV_STEPS]),
    .word_i  (div_word[DIV_STEPS]),
    .valid_o (out_valid),
    .pix_o   (out_data)
  );

endmodule

>>> src/rgbhsl_checker.sv
// ----------------------------------------------------------------------------
// rgbhsl_checker
// Port-level checks on the RGB to HSL converter, bound to the top level.
// ----------------------------------------------------------------------------
module rgbhsl_checker
  import rgbhsl_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     start,
  input logic     busy,
  input logic     out_valid,
  input out_pix_t out_data
);

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, PIPE_LATENCY))
    else $error("result without matching request");

  a_gray_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.is_gray |->
      out_data.hue_q == 15'd0 && out_data.saturation_q == 16'd0)
    else $error("gray pixel with nonzero hue or saturation");

  a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.hue_q < HUE_FULL_Q)
    else $error("hue out of range");

  a_color_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.is_gray |-> out_data.saturation_q != 16'd0)
    else $error("colored pixel with zero saturation");

endmodule

bind rgb_to_hsl_converter rgbhsl_checker u_rgbhsl_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);

>>> test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench for rgb_to_hsl_converter. Directed corner pixels with set gaps,
// then random pixels biased toward gray, tied and extreme components with
// random gaps. A local HSL model predicts every result. The monitor checks
// each result strobe field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb
  import rgbhsl_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SIXTY_DEG_Q   = 3840;
  localparam int FULL_TURN_Q   = 23040;
  localparam int SAT_SCALE     = 65535;
  localparam int N_RANDOM      = 400;
  localparam int IDLE_LIMIT    = 1000;

  typedef struct {
    in_pix_t     pix;
    int unsigned gap;
  } pix_req_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     start = 1'b0;
  logic     busy;
  in_pix_t  in_data = '0;
  logic     out_valid;
  out_pix_t out_data;

  pix_req_t    pending_reqs[$];
  out_pix_t    expected_hsl[$];
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;

  rgb_to_hsl_converter u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  always #6 clk = ~clk;

  function automatic out_pix_t hsl_of(in_pix_t p);
    int unsigned r, g, b, mx, mn, d, sum, den, hue, sat;
    int          num;
    out_pix_t    o;
    r   = 32'(p.red);
    g   = 32'(p.green);
    b   = 32'(p.blue);
    mx  = (r > g) ? r : g;
    mx  = (mx > b) ? mx : b;
    mn  = (r < g) ? r : g;
    mn  = (mn < b) ? mn : b;
    d   = mx - mn;
    sum = mx + mn;
    hue = 0;
    sat = 0;
    if (d != 0) begin
      den = (sum <= 255) ? sum : 510 - sum;
      sat = (2 * d * SAT_SCALE + den) / (2 * den);
      if (sat > SAT_SCALE) sat = SAT_SCALE;
      if (mx == r) begin
        num = SIXTY_DEG_Q * (int'(g) - int'(b));
        if (num < 0) num += FULL_TURN_Q * int'(d);
      end else if (mx == g) begin
        num = SIXTY_DEG_Q * (int'(b) - int'(r)) + 2 * SIXTY_DEG_Q * int'(d);
      end else begin
        num = SIXTY_DEG_Q * (int'(r) - int'(g)) + 4 * SIXTY_DEG_Q * int'(d);
      end
      if (num < 0) num = 0;
      hue = (2 * int'(num) + d) / (2 * d);
      if (hue >= FULL_TURN_Q) hue -= FULL_TURN_Q;
    end
    o.hue_q         = hue[14:0];
    o.lightness_sum = sum[8:0];
    o.saturation_q  = sat[15:0];
    o.is_gray       = (d == 0);
    return o;
  endfunction

  function automatic in_pix_t random_pixel();
    in_pix_t p;
    int unsigned v;
    p = in_pix_t'(24'($urandom()));
    v = $urandom_range(255);
    case ($urandom_range(0, 9))
      0: begin
        p.red   = 8'(v);
        p.green = 8'(v);
        p.blue  = 8'(v);
      end
      1: p.green = p.red;
      2: p.blue = p.green;
      3: p.blue = p.red;
      4: begin
        p.red   = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        p.green = $urandom_range(0, 1) ? 8'(255 - $urandom_range(3))
                                       : 8'($urandom_range(3));
      end
      5: begin
        p.green = 8'(p.red + $urandom_range(0, 2) - 1);
        p.blue  = 8'(p.red + $urandom_range(0, 2) - 1);
      end
      default: ;
    endcase
    return p;
  endfunction

  task automatic queue_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                             input int unsigned gap);
    pix_req_t q;
    q.pix.red   = r;
    q.pix.green = g;
    q.pix.blue  = b;
    q.gap       = gap;
    pending_reqs.push_back(q);
  endtask

  task automatic flag_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $time, what);
    mismatches++;
  endtask

  // driver: hold each request until accepted, then wait out the next gap
  logic        drv_start;
  logic        gap_loaded = 1'b0;
  int unsigned gap_left = 0;
  pix_req_t    drv_req;

  always @(posedge clk) begin
    if (!rst_n) begin
      start      <= 1'b0;
      in_data    <= '0;
      gap_loaded = 1'b0;
    end else begin
      drv_start = start;
      if (start && !busy) begin
        expected_hsl.push_back(hsl_of(in_data));
        drv_start = 1'b0;
      end
      if (!drv_start && pending_reqs.size() != 0) begin
        if (!gap_loaded) begin
          gap_left   = pending_reqs[0].gap;
          gap_loaded = 1'b1;
        end
        if (gap_left > 0) begin
          gap_left--;
        end else begin
          drv_req    = pending_reqs.pop_front();
          in_data    <= drv_req.pix;
          drv_start  = 1'b1;
          gap_loaded = 1'b0;
        end
      end
      start <= drv_start;
    end
  end

  // monitor
  always @(posedge clk) begin
    out_pix_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (expected_hsl.size() == 0) begin
        flag_mismatch("result with no request pending");
      end else begin
        want = expected_hsl.pop_front();
        if (out_data.hue_q !== want.hue_q)
          flag_mismatch($sformatf("hue_q got %0d want %0d", out_data.hue_q, want.hue_q));
        if (out_data.lightness_sum !== want.lightness_sum)
          flag_mismatch($sformatf("lightness_sum got %0d want %0d",
                                  out_data.lightness_sum, want.lightness_sum));
        if (out_data.saturation_q !== want.saturation_q)
          flag_mismatch($sformatf("saturation_q got %0d want %0d",
                                  out_data.saturation_q, want.saturation_q));
        if (out_data.is_gray !== want.is_gray)
          flag_mismatch($sformatf("is_gray got %0b want %0b",
                                  out_data.is_gray, want.is_gray));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid === 1'b1) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    bit burst;
    queue_pixel(8'd0, 8'd0, 8'd0, 0);
    queue_pixel(8'd255, 8'd255, 8'd255, 0);
    queue_pixel(8'd128, 8'd128, 8'd128, 3);
    queue_pixel(8'd255, 8'd0, 8'd0, 0);
    queue_pixel(8'd0, 8'd255, 8'd0, 1);
    queue_pixel(8'd0, 8'd0, 8'd255, 0);
    queue_pixel(8'd255, 8'd255, 8'd0, 0);
    queue_pixel(8'd0, 8'd255, 8'd255, 2);
    queue_pixel(8'd255, 8'd0, 8'd255, 0);
    queue_pixel(8'd200, 8'd10, 8'd50, 0);
    queue_pixel(8'd255, 8'd0, 8'd1, 5);
    queue_pixel(8'd1, 8'd0, 8'd0, 0);
    queue_pixel(8'd0, 8'd0, 8'd1, 0);
    queue_pixel(8'd0, 8'd1, 8'd0, 12);
    queue_pixel(8'd254, 8'd255, 8'd255, 0);
    queue_pixel(8'd255, 8'd254, 8'd254, 0);
    queue_pixel(8'd254, 8'd0, 8'd0, 0);
    queue_pixel(8'd255, 8'd1, 8'd0, 0);
    queue_pixel(8'd255, 8'd1, 8'd1, 7);
    queue_pixel(8'd128, 8'd127, 8'd127, 0);
    queue_pixel(8'd127, 8'd128, 8'd128, 0);
    queue_pixel(8'd10, 8'd20, 8'd30, 0);
    queue_pixel(8'd85, 8'd170, 8'd255, 0);
    burst = 1'b0;
    for (int i = 0; i < N_RANDOM; i++) begin
      pix_req_t q;
      if (i % 40 == 0) burst = ($urandom_range(0, 3) == 0);
      q.pix = random_pixel();
      q.gap = burst ? 0 : $urandom_range(0, 12);
      pending_reqs.push_back(q);
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    @(negedge clk);
    while (pending_reqs.size() != 0 || start || expected_hsl.size() != 0) @(negedge clk);
    repeat (PIPE_LATENCY + 4) @(negedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
src/rgbhsl_pkg.sv
src/rgbhsl_prep.sv
src/rgbhsl_div_stage.sv
src/rgbhsl_round.sv
src/rgb_to_hsl_converter.sv
src/rgbhsl_checker.sv
test/tb.sv
